@@ sv/ebci_pkg.sv @@
// Package for the blink-code error indicator.
// Holds the item kinds, register indexes, field widths and reset values.
// No dependencies.
package ebci_pkg;

    // Field widths fixed by the item layout.
    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 3;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Kinds of input item, carried in tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_ADD   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } t_func;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE        = 1'd1;

    // Register reset values in ticks.
    localparam logic [TIME_W-1:0] FLASH_PERIOD_RST = 16'd600;
    localparam logic [TIME_W-1:0] PAUSE_RST        = 16'd3000;

    // Top of the saturating elapsed counter.
    localparam logic [TIME_W-1:0] ELAPSED_MAX = 16'hFFFF;

endpackage

@@ sv/error_blink_code_indicator_unit.sv @@
// Top level of the blink-code error indicator.
// Keeps pending error codes, runs the LED blink sequencer and answers queries.
// Depends on ebci_pkg.
//
// Channel   Direction  Transfer when             Payload
// s_axis    in         tvalid & tready           tuser = func, tdata = code
// m_axis    out        tvalid & tready           tdata = led, highest_code, code_present
// cfg       in         valid & ready (always 1)  index, data (16 bit)
//
// One item passes through an input register and a result register; a new item can be
// taken in every cycle while the output is not stalled. The state registers update on
// the same edge that moves an item from the input register into the result register.
// Reset clears the pending set, the sequencer and the registers to 600 and 3000 ticks.
// A stall on the output holds the result register and, once the input register is
// also full, drops s_axis tready; nothing is lost or repeated.
module error_blink_code_indicator_unit #(
    parameter int NUM_CODES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [2:0] code, [7:3] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] func
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] led, [3:1] highest_code, [4] code_present, [7:5] zero
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ebci_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ebci_pkg::TIME_W-1:0]    i_cfg_data
);

    // Configuration registers.
    logic [ebci_pkg::TIME_W-1:0] r_flash_period;
    logic [ebci_pkg::TIME_W-1:0] r_pause;

    // Input register.
    logic                        r_in_valid;
    ebci_pkg::t_func             r_in_func;
    logic [ebci_pkg::CODE_W-1:0] r_in_code;

    // Indicator state.
    logic [NUM_CODES-1:0]        r_pending;
    logic [NUM_CODES-1:0]        n_pending;
    logic [ebci_pkg::CODE_W-1:0] r_highest;
    logic [ebci_pkg::CODE_W-1:0] n_highest;
    logic [ebci_pkg::CODE_W-1:0] r_blink_count;
    logic [ebci_pkg::CODE_W-1:0] n_blink_count;
    logic                        r_led_lit;
    logic                        n_led_lit;
    logic [ebci_pkg::TIME_W-1:0] r_elapsed;
    logic [ebci_pkg::TIME_W-1:0] n_elapsed;
    logic                        n_present;

    // Result register.
    logic                        r_out_valid;
    logic                        r_out_led;
    logic [ebci_pkg::CODE_W-1:0] r_out_highest;
    logic                        r_out_present;

    logic                        advance;
    logic [ebci_pkg::TIME_W-1:0] elapsed_inc;

    // The item in the input register moves on when the result register is free or drains.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    // Configuration writes; indexes outside the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_period <= ebci_pkg::FLASH_PERIOD_RST;
            r_pause        <= ebci_pkg::PAUSE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ebci_pkg::REG_FLASH_PERIOD) begin
                r_flash_period <= i_cfg_data;
            end else if (i_cfg_index == ebci_pkg::REG_PAUSE) begin
                r_pause <= i_cfg_data;
            end
        end
    end

    // Input register: load on every input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_func <= ebci_pkg::t_func'(i_s_axis_tuser);
            r_in_code <= i_s_axis_tdata[ebci_pkg::CODE_W-1:0];
        end
    end

    assign elapsed_inc = (r_elapsed != ebci_pkg::ELAPSED_MAX) ?
                         r_elapsed + ebci_pkg::TIME_W'(1) : r_elapsed;

    // Next state for the item in the input register.
    always_comb begin
        n_pending     = r_pending;
        n_blink_count = r_blink_count;
        n_led_lit     = r_led_lit;
        n_elapsed     = r_elapsed;
        n_present     = 1'b0;
        n_highest     = '0;
        unique case (r_in_func)
            ebci_pkg::FUNC_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_highest == '0) begin
                    n_led_lit = 1'b0;
                end else if (r_blink_count < r_highest) begin
                    if (elapsed_inc >= r_flash_period) begin
                        if (r_led_lit) begin
                            n_led_lit     = 1'b0;
                            n_blink_count = r_blink_count + ebci_pkg::CODE_W'(1);
                        end else begin
                            n_led_lit = 1'b1;
                        end
                        n_elapsed = '0;
                    end
                end else if (elapsed_inc >= r_pause) begin
                    n_elapsed     = '0;
                    n_blink_count = '0;
                end
            end
            ebci_pkg::FUNC_ADD: begin
                // Code zero is never stored; a code beyond the set matches no flag.
                for (int i = 1; i < NUM_CODES; i++) begin
                    if (int'(r_in_code) == i) begin
                        n_pending[i] = 1'b1;
                    end
                end
            end
            ebci_pkg::FUNC_CLEAR: begin
                for (int i = 1; i < NUM_CODES; i++) begin
                    if (int'(r_in_code) == i) begin
                        n_pending[i] = 1'b0;
                    end
                end
            end
            ebci_pkg::FUNC_QUERY: begin
                for (int i = 1; i < NUM_CODES; i++) begin
                    if (int'(r_in_code) == i && r_pending[i]) begin
                        n_present = 1'b1;
                    end
                end
            end
            default: begin
                n_present = 1'b0;
            end
        endcase
        // Highest pending code over the whole set.
        for (int i = 1; i < NUM_CODES; i++) begin
            if (n_pending[i]) begin
                n_highest = ebci_pkg::CODE_W'(i);
            end
        end
    end

    // State registers update as the item passes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending     <= '0;
            r_highest     <= '0;
            r_blink_count <= '0;
            r_led_lit     <= 1'b0;
            r_elapsed     <= '0;
        end else if (advance) begin
            r_pending     <= n_pending;
            r_highest     <= n_highest;
            r_blink_count <= n_blink_count;
            r_led_lit     <= n_led_lit;
            r_elapsed     <= n_elapsed;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_led     <= n_led_lit;
            r_out_highest <= n_highest;
            r_out_present <= n_present;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_present, r_out_highest, r_out_led};

    // The LED lights only on a tick while some code is pending.
    a_led_needs_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_led_lit) |-> ($past(r_highest) != '0 &&
                              $past(r_in_func) == ebci_pkg::FUNC_TICK))
        else $error("LED lit without a pending code");

    // The indicator state moves only when an item passes.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_highest) && $stable(r_elapsed) && $stable(r_pending)))
        else $error("indicator state changed without an item");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with an empty result register");

endmodule

@@ bench/tb_error_blink_code_indicator_unit.sv @@
// Testbench for error_blink_code_indicator_unit: directed and random tests.
// A built-in predictor of the pending set and blink sequencer checks every result.
// Depends on ebci_pkg and the error_blink_code_indicator_unit RTL.
`timescale 1ns / 100ps

module tb_error_blink_code_indicator_unit;

    localparam int NUM_CODES   = 8;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 4;
    localparam int PHASE_ITEMS = 150;

    // One result word: [0] led, [3:1] highest_code, [4] code_present.
    typedef struct packed {
        logic       present;
        logic [2:0] highest;
        logic       led;
    } t_led_status;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = '0;
    logic [1:0]  i_s_axis_tuser = ebci_pkg::FUNC_TICK;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [ebci_pkg::CFG_IDX_W-1:0] i_cfg_index = ebci_pkg::REG_FLASH_PERIOD;
    logic [ebci_pkg::TIME_W-1:0]    i_cfg_data = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic        o_cfg_ready;

    // Predictor state and its copy of the timing registers.
    logic [NUM_CODES-1:0]        code_set;
    logic [2:0]                  top_code;
    logic [2:0]                  flash_num;
    logic                        lamp_on;
    logic [ebci_pkg::TIME_W-1:0] ticks_since;
    logic [ebci_pkg::TIME_W-1:0] period_ticks;
    logic [ebci_pkg::TIME_W-1:0] pause_ticks;

    t_led_status status_q[$];
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count = 0;
    int unsigned src_gap_max = 7;
    int unsigned snk_gap_max = 7;
    int unsigned hold_request = 0;

    error_blink_code_indicator_unit #(
        .NUM_CODES(NUM_CODES)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, status_q.size());
            $display("FAIL error_blink_code_indicator_unit");
            $finish;
        end
    end

    // Predictor state after reset.
    function automatic void clear_indicator();
        code_set     = '0;
        top_code     = '0;
        flash_num    = '0;
        lamp_on      = 1'b0;
        ticks_since  = '0;
        period_ticks = ebci_pkg::FLASH_PERIOD_RST;
        pause_ticks  = ebci_pkg::PAUSE_RST;
    endfunction

    // Applies one item to the predictor and returns the status it should produce.
    function automatic t_led_status step_indicator(input ebci_pkg::t_func kind,
                                                   input logic [2:0] code);
        t_led_status st;
        logic        known;
        known = (code != 3'd0) && (int'(code) < NUM_CODES);
        st.present = 1'b0;
        unique case (kind)
            ebci_pkg::FUNC_TICK: begin
                if (ticks_since != ebci_pkg::ELAPSED_MAX)
                    ticks_since = ticks_since + 1'b1;
                if (top_code == 3'd0) begin
                    lamp_on = 1'b0;
                end else if (flash_num < top_code) begin
                    // Flash phase: toggle once the period has run out.
                    if (ticks_since >= period_ticks) begin
                        if (lamp_on)
                            flash_num = flash_num + 1'b1;
                        lamp_on     = ~lamp_on;
                        ticks_since = '0;
                    end
                end else if (ticks_since >= pause_ticks) begin
                    // End of the dark pause restarts the sequence.
                    ticks_since = '0;
                    flash_num   = '0;
                end
            end
            ebci_pkg::FUNC_ADD: begin
                if (known && !code_set[code]) begin
                    code_set[code] = 1'b1;
                    if (code > top_code)
                        top_code = code;
                end
            end
            ebci_pkg::FUNC_CLEAR: begin
                if (known) begin
                    code_set[code] = 1'b0;
                    top_code = '0;
                    for (int i = 1; i < NUM_CODES; i++)
                        if (code_set[i])
                            top_code = i[2:0];
                end
            end
            default: begin
                st.present = known && code_set[code];
            end
        endcase
        st.led     = lamp_on;
        st.highest = top_code;
        return st;
    endfunction

    // Compares one result transfer with the oldest expected status.
    task automatic check_status(input logic [7:0] word);
        t_led_status got;
        t_led_status want;
        got = t_led_status'(word[4:0]);
        results_seen++;
        if (status_q.size() == 0) begin
            $error("Result 0x%02h arrived with no expected status pending.", word);
            mismatches++;
        end else begin
            want = status_q.pop_front();
            if (got.led !== want.led) begin
                $error("led: expected %0d, got %0d", want.led, got.led);
                mismatches++;
            end
            if (got.highest !== want.highest) begin
                $error("highest_code: expected %0d, got %0d", want.highest, got.highest);
                mismatches++;
            end
            if (got.present !== want.present) begin
                $error("code_present: expected %0d, got %0d", want.present, got.present);
                mismatches++;
            end
        end
    endtask

    // Result sink: checks each transfer and stalls at random or on a hold request.
    initial begin : result_sink
        int unsigned wait_left;
        int unsigned hold_left;
        logic        next_ready;
        wait_left = 0;
        hold_left = 0;
        wait (i_rst_n == 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                check_status(o_m_axis_tdata);
                wait_left = $urandom_range(0, snk_gap_max);
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                next_ready = 1'b0;
                hold_left--;
            end else if (wait_left != 0) begin
                next_ready = 1'b0;
                wait_left--;
            end else begin
                next_ready = 1'b1;
            end
            i_m_axis_tready <= next_ready;
        end
    end

    // Sends one item after a random gap and records its expected status.
    // Valid stays high after the transfer so a back-to-back item needs no toggle.
    task automatic send_item(input ebci_pkg::t_func kind, input logic [2:0] code);
        int unsigned gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {5'b0, code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        status_q.push_back(step_indicator(kind, code));
        items_sent++;
    endtask

    // Stops the input stream and waits until every result has been checked.
    task automatic wait_for_idle();
        i_s_axis_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Writes both timing registers while the block is idle.
    task automatic set_timing(input logic [ebci_pkg::TIME_W-1:0] flash,
                              input logic [ebci_pkg::TIME_W-1:0] pause);
        wait_for_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= ebci_pkg::REG_FLASH_PERIOD;
        i_cfg_data  <= flash;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_ticks = flash;
        i_cfg_index <= ebci_pkg::REG_PAUSE;
        i_cfg_data  <= pause;
        do @(posedge i_clk); while (!o_cfg_ready);
        pause_ticks = pause;
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly ticks and real codes, with some code zero noise.
    task automatic send_random_item();
        int unsigned     pick;
        ebci_pkg::t_func kind;
        logic [2:0]      code;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            kind = ebci_pkg::FUNC_TICK;
        else if (pick < 72)
            kind = ebci_pkg::FUNC_ADD;
        else if (pick < 85)
            kind = ebci_pkg::FUNC_CLEAR;
        else
            kind = ebci_pkg::FUNC_QUERY;
        if ($urandom_range(0, 9) == 0)
            code = 3'($urandom_range(0, 7));
        else
            code = 3'($urandom_range(1, 7));
        // Ticks carry a random code too, so every code bit toggles on every kind.
        send_item(kind, code);
    endtask

    // Nothing pending: the LED stays dark and queries answer zero.
    task automatic test_idle_after_reset();
        send_item(ebci_pkg::FUNC_TICK, 3'd0);
        send_item(ebci_pkg::FUNC_QUERY, 3'd7);
        send_item(ebci_pkg::FUNC_QUERY, 3'd0);
    endtask

    // Code zero is never pending and changes nothing.
    task automatic test_code_zero();
        send_item(ebci_pkg::FUNC_ADD, 3'd0);
        send_item(ebci_pkg::FUNC_CLEAR, 3'd0);
        send_item(ebci_pkg::FUNC_QUERY, 3'd0);
        send_item(ebci_pkg::FUNC_TICK, 3'd7);
    endtask

    // Adds, a repeated add, queries and clears that recompute the highest code.
    task automatic test_pending_set();
        send_item(ebci_pkg::FUNC_ADD, 3'd3);
        send_item(ebci_pkg::FUNC_ADD, 3'd3);
        send_item(ebci_pkg::FUNC_ADD, 3'd7);
        send_item(ebci_pkg::FUNC_ADD, 3'd1);
        send_item(ebci_pkg::FUNC_QUERY, 3'd7);
        send_item(ebci_pkg::FUNC_QUERY, 3'd2);
        send_item(ebci_pkg::FUNC_CLEAR, 3'd7);
        send_item(ebci_pkg::FUNC_QUERY, 3'd7);
        send_item(ebci_pkg::FUNC_CLEAR, 3'd1);
        send_item(ebci_pkg::FUNC_CLEAR, 3'd3);
        send_item(ebci_pkg::FUNC_TICK, 3'd0);
    endtask

    // Short blinks, then a clear drops the highest code below the blink count.
    task automatic test_short_blink();
        set_timing(16'd1, 16'd2);
        send_item(ebci_pkg::FUNC_ADD, 3'd1);
        send_item(ebci_pkg::FUNC_ADD, 3'd3);
        repeat (4) send_item(ebci_pkg::FUNC_TICK, 3'd0);
        send_item(ebci_pkg::FUNC_CLEAR, 3'd3);
        repeat (3) send_item(ebci_pkg::FUNC_TICK, 3'd0);
    endtask

    // Random traffic under several timing settings, including zero and reset values.
    task automatic test_random_phases();
        logic [ebci_pkg::TIME_W-1:0] flash_set[7];
        logic [ebci_pkg::TIME_W-1:0] pause_set[7];
        flash_set = '{16'd1, 16'd0, 16'd2, 16'd3, 16'($urandom_range(1, 4)),
                      ebci_pkg::FLASH_PERIOD_RST, 16'd1};
        pause_set = '{16'd1, 16'd0, 16'd7, 16'd1, 16'($urandom_range(1, 12)),
                      ebci_pkg::PAUSE_RST, 16'hFFFF};
        for (int p = 0; p < 7; p++) begin
            set_timing(flash_set[p], pause_set[p]);
            // One phase runs without idling on either side.
            src_gap_max = (p == 3) ? 0 : 7;
            snk_gap_max = (p == 3) ? 0 : 7;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Long receiver stall while items keep coming.
                if (p == 2 && n == 10)
                    hold_request = 64;
                send_random_item();
            end
        end
        src_gap_max = 7;
        snk_gap_max = 7;
    endtask

    // Test sequence.
    initial begin
        clear_indicator();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_after_reset();
        test_code_zero();
        test_pending_set();
        test_short_blink();
        test_random_phases();
        wait_for_idle();
        $display("Sent %0d items and checked %0d results over %0d timing settings.",
                 items_sent, results_seen, settings_used);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0 && status_q.size() == 0) begin
            $display("PASS error_blink_code_indicator_unit");
        end else begin
            $display("FAIL error_blink_code_indicator_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ebci_pkg.sv
sv/error_blink_code_indicator_unit.sv
bench/tb_error_blink_code_indicator_unit.sv
